// File: rtl/tfpd_pkg.sv
// ----------------------------------------------------------------------------
// tfpd_pkg : shared types and constants for the tape follow PD controller
// Field widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package tfpd_pkg;

   // field widths
   localparam int SENSOR_W   = 4;
   localparam int WEIGHT_W   = 11;
   localparam int GAIN_W     = 8;
   localparam int SPEED_W    = 10;
   localparam int OUT_W      = 11;
   localparam int ERR_W      = 14;
   localparam int RUN_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // internal datapath widths
   localparam int DE_W     = ERR_W + 1;       // error change, signed
   localparam int DMAG_W   = ERR_W;           // magnitude of error change
   localparam int SPAN_W   = RUN_W + 1;       // run length sum
   localparam int PROD_W   = 22;              // gain products
   localparam int T_W      = PROD_W + 2;      // combined sum before scaling
   localparam int FRAC_W   = 8;               // fraction bits, gains are Q0.8
   localparam int S_W      = T_W - FRAC_W;    // scaled PD sum
   localparam int CTL_W    = S_W + 1;         // negated control
   localparam int WIDE_W   = CTL_W + 1;       // control plus or minus base
   localparam int CNT_W    = 5;

   // sequencer step counts
   localparam int MUL_STEPS = GAIN_W;
   localparam int DIV_STEPS = PROD_W;

   localparam int SAT_LIMIT = 1023;

   // register reset values
   localparam logic [WEIGHT_W-1:0] WEIGHT_NEWEST_RST = 11'd568;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MIDDLE_RST = 11'd768;
   localparam logic [WEIGHT_W-1:0] WEIGHT_OLDEST_RST = 11'd256;
   localparam logic [GAIN_W-1:0]   PROP_GAIN_RST     = 8'd10;
   localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST    = 8'd10;
   localparam logic [SPEED_W-1:0]  BASE_SPEED_RST    = 10'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_NEWEST = 3'd0,
      CSR_WEIGHT_MIDDLE = 3'd1,
      CSR_WEIGHT_OLDEST = 3'd2,
      CSR_PROP_GAIN     = 3'd3,
      CSR_DERIV_GAIN    = 3'd4,
      CSR_BASE_SPEED    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIX,
      ST_FIN
   } state_type;

endpackage

// File: rtl/tape_follow_pd_controller_top.sv
// ----------------------------------------------------------------------------
// tape_follow_pd_controller_top : PD steering controller for tape following
// Weights the sensor history into an error, forms P plus D control over a
// bit-serial multiplier and a restoring divider, and drives both motors.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_sensor_bits
//  rsp      out        rsp_valid/rsp_ready    rsp_left/right_speed, steer_value
//  csr      in         csr_valid/csr_ready    csr_index, csr_data
//
//  one item goes through an accept step, 8 shift-add steps (one gain
//  bit each), 22 divider steps (one quotient bit each), a correction
//  step and an output step before the next acceptance
//  the divider is skipped when the run length sum is zero
//  a result waiting in the output register does not hold off the next
//  item; only the final output cycle waits for the register to free up
//  synchronous active-high reset; csr writes are always taken
// ----------------------------------------------------------------------------
module tape_follow_pd_controller_top #(
   parameter int HISTORY_DEPTH = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [tfpd_pkg::SENSOR_W-1:0]          req_sensor_bits,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [tfpd_pkg::OUT_W-1:0]      rsp_left_speed,
   output logic signed [tfpd_pkg::OUT_W-1:0]      rsp_right_speed,
   output logic signed [tfpd_pkg::OUT_W-1:0]      rsp_steer_value,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tfpd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tfpd_pkg::CSR_DATA_W-1:0]        csr_data
);
   import tfpd_pkg::*;

   localparam int NROWS = (HISTORY_DEPTH < 3) ? HISTORY_DEPTH : 3;
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
   localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(SAT_LIMIT);
   localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI;

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > SAT_HI) r = SAT_HI[OUT_W-1:0];
      else if (v < SAT_LO) r = SAT_LO[OUT_W-1:0];
      else r = v[OUT_W-1:0];
      return r;
   endfunction

   // configuration registers
   logic [WEIGHT_W-1:0] w_newest_ff, w_middle_ff, w_oldest_ff;
   logic [GAIN_W-1:0]   prop_gain_ff, deriv_gain_ff;
   logic [SPEED_W-1:0]  base_speed_ff;

   // controller state
   logic [SENSOR_W-1:0]     hist_ff [HISTORY_DEPTH];
   logic signed [ERR_W-1:0] last_err_ff, earlier_err_ff;
   logic [RUN_W-1:0]        run_ff, prev_run_ff;

   // sequencer and datapath
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [PROD_W-1:0] a_acc_ff, a_acc_in, a_mc_ff, a_mc_in;
   logic [PROD_W-1:0]       b_acc_ff, b_acc_in, b_mc_ff, b_mc_in;
   logic [GAIN_W-1:0]       pg_sh_ff, pg_sh_in, dg_sh_ff, dg_sh_in;
   logic                    b_neg_ff, b_neg_in, dz_ff, dz_in;
   logic [SPAN_W-1:0]       d_ff, d_in;
   logic [SPAN_W-1:0]       rem_ff, rem_in;
   logic signed [CTL_W-1:0] ctl_ff, ctl_in;
   logic signed [OUT_W-1:0] left_ff, left_in, right_ff, right_in, steer_ff, steer_in;

   // control strobes
   logic req_fire, mul_step, div_step, fix_step, load_out;

   // error and run bookkeeping
   logic [SENSOR_W-1:0]     rows [NROWS];
   logic [WEIGHT_W-1:0]     wts [3];
   logic signed [ERR_W-1:0] err;
   logic                    err_changed;
   logic signed [DE_W-1:0]  de_full;
   logic [DMAG_W-1:0]       de_mag;
   logic [SPAN_W-1:0]       d_full;
   logic [RUN_W-1:0]        run_in, prev_run_in;
   logic signed [ERR_W-1:0] earlier_err_in;

   // divider and correction
   logic [SPAN_W:0]         trial;
   logic                    trial_ge;
   logic signed [T_W-1:0]   q_ext, qb, t_sum, t_up;
   logic                    rnz;
   logic signed [S_W-1:0]   s_val;
   logic signed [WIDE_W-1:0] ctl_wide, base_wide;

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = left_ff;
   assign rsp_right_speed = right_ff;
   assign rsp_steer_value = steer_ff;

   // --------------------------------------------------------------- fsm
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_MUL;
         ST_MUL:  if (cnt_ff == MUL_LAST) state_in = dz_ff ? ST_FIX : ST_DIV;
         ST_DIV:  if (cnt_ff == DIV_LAST) state_in = ST_FIX;
         ST_FIX:  state_in = ST_FIN;
         ST_FIN:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      req_fire  = req_ready && req_valid;
      mul_step  = (state_ff == ST_MUL);
      div_step  = (state_ff == ST_DIV);
      fix_step  = (state_ff == ST_FIX);
      load_out  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   end

   // ------------------------------------------------------ error at accept
   always_comb begin
      wts[0] = w_newest_ff;
      wts[1] = w_middle_ff;
      wts[2] = w_oldest_ff;
      rows[0] = req_sensor_bits;
      for (int i = 1; i < NROWS; i++) rows[i] = hist_ff[i-1];
      err = '0;
      for (int i = 0; i < NROWS; i++) begin
         // sensor 1 alone pulls left, sensor 2 alone pulls right
         if (rows[i][1] && !rows[i][2])
            err = err - signed'({{(ERR_W-WEIGHT_W){1'b0}}, wts[i]});
         else if (!rows[i][1] && rows[i][2])
            err = err + signed'({{(ERR_W-WEIGHT_W){1'b0}}, wts[i]});
      end
   end

   always_comb begin
      err_changed    = (err != last_err_ff);
      earlier_err_in = err_changed ? last_err_ff : earlier_err_ff;
      de_full        = {err[ERR_W-1], err} - {earlier_err_in[ERR_W-1], earlier_err_in};
      de_mag         = de_full[DE_W-1] ? DMAG_W'(-de_full) : de_full[DMAG_W-1:0];
      if (err_changed) begin
         d_full      = SPAN_W'(run_ff) + SPAN_W'(1);
         prev_run_in = run_ff;
         run_in      = RUN_W'(2);
      end else begin
         d_full      = SPAN_W'(run_ff) + SPAN_W'(prev_run_ff);
         prev_run_in = prev_run_ff;
         run_in      = (run_ff == '1) ? run_ff : run_ff + RUN_W'(1);
      end
   end

   // ---------------------------------------------------------- datapath
   always_comb begin
      trial    = {rem_ff, b_acc_ff[PROD_W-1]};
      trial_ge = (trial >= {1'b0, d_ff});

      // floor quotient of the derivative term, then the rounding fix-up
      q_ext = signed'({{(T_W-PROD_W){1'b0}}, b_acc_ff});
      rnz   = !dz_ff && (rem_ff != '0);
      if (dz_ff)         qb = '0;
      else if (!b_neg_ff) qb = q_ext;
      else if (rnz)      qb = ~q_ext;
      else               qb = -q_ext;
      t_sum = {{(T_W-PROD_W){a_acc_ff[PROD_W-1]}}, a_acc_ff} + qb;
      t_up  = t_sum + T_W'(rnz) + T_W'(255);
      s_val = t_sum[T_W-1] ? t_up[T_W-1:FRAC_W] : t_sum[T_W-1:FRAC_W];

      ctl_wide  = {ctl_ff[CTL_W-1], ctl_ff};
      base_wide = signed'({{(WIDE_W-SPEED_W){1'b0}}, base_speed_ff});
   end

   always_comb begin
      a_acc_in = a_acc_ff;
      a_mc_in  = a_mc_ff;
      b_acc_in = b_acc_ff;
      b_mc_in  = b_mc_ff;
      pg_sh_in = pg_sh_ff;
      dg_sh_in = dg_sh_ff;
      b_neg_in = b_neg_ff;
      dz_in    = dz_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      ctl_in   = ctl_ff;
      left_in  = left_ff;
      right_in = right_ff;
      steer_in = steer_ff;
      if (req_fire) begin
         a_acc_in = '0;
         a_mc_in  = {{(PROD_W-ERR_W){err[ERR_W-1]}}, err};
         b_acc_in = '0;
         b_mc_in  = {{(PROD_W-DMAG_W){1'b0}}, de_mag};
         pg_sh_in = prop_gain_ff;
         dg_sh_in = deriv_gain_ff;
         b_neg_in = de_full[DE_W-1];
         d_in     = d_full;
         dz_in    = (d_full == '0);
         rem_in   = '0;
         cnt_in   = '0;
      end
      if (mul_step) begin
         // one bit of each gain per cycle, lsb first
         if (pg_sh_ff[0]) a_acc_in = a_acc_ff + a_mc_ff;
         if (dg_sh_ff[0]) b_acc_in = b_acc_ff + b_mc_ff;
         a_mc_in  = a_mc_ff <<< 1;
         b_mc_in  = b_mc_ff << 1;
         pg_sh_in = pg_sh_ff >> 1;
         dg_sh_in = dg_sh_ff >> 1;
         cnt_in   = (cnt_ff == MUL_LAST) ? '0 : cnt_ff + CNT_W'(1);
      end
      if (div_step) begin
         // dividend shifts out msb first, quotient bits shift in
         rem_in   = trial_ge ? SPAN_W'(trial - {1'b0, d_ff}) : trial[SPAN_W-1:0];
         b_acc_in = {b_acc_ff[PROD_W-2:0], trial_ge};
         cnt_in   = cnt_ff + CNT_W'(1);
      end
      if (fix_step) ctl_in = -{s_val[S_W-1], s_val};
      if (load_out) begin
         left_in  = sat_out(ctl_wide - base_wide);
         right_in = sat_out(ctl_wide + base_wide);
         steer_in = sat_out(ctl_wide);
      end
   end

   always_comb begin
      if (load_out)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   // --------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) hist_ff[i] <= '0;
         last_err_ff    <= '0;
         earlier_err_ff <= '0;
         run_ff         <= '0;
         prev_run_ff    <= '0;
      end else if (req_fire) begin
         hist_ff[0] <= req_sensor_bits;
         for (int i = 1; i < HISTORY_DEPTH; i++) hist_ff[i] <= hist_ff[i-1];
         last_err_ff    <= err;
         earlier_err_ff <= earlier_err_in;
         run_ff         <= run_in;
         prev_run_ff    <= prev_run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_newest_ff   <= WEIGHT_NEWEST_RST;
         w_middle_ff   <= WEIGHT_MIDDLE_RST;
         w_oldest_ff   <= WEIGHT_OLDEST_RST;
         prop_gain_ff  <= PROP_GAIN_RST;
         deriv_gain_ff <= DERIV_GAIN_RST;
         base_speed_ff <= BASE_SPEED_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WEIGHT_NEWEST: w_newest_ff   <= csr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_MIDDLE: w_middle_ff   <= csr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_OLDEST: w_oldest_ff   <= csr_data[WEIGHT_W-1:0];
            CSR_PROP_GAIN:     prop_gain_ff  <= csr_data[GAIN_W-1:0];
            CSR_DERIV_GAIN:    deriv_gain_ff <= csr_data[GAIN_W-1:0];
            CSR_BASE_SPEED:    base_speed_ff <= csr_data[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_acc_ff <= a_acc_in;
      a_mc_ff  <= a_mc_in;
      b_acc_ff <= b_acc_in;
      b_mc_ff  <= b_mc_in;
      pg_sh_ff <= pg_sh_in;
      dg_sh_ff <= dg_sh_in;
      b_neg_ff <= b_neg_in;
      dz_ff    <= dz_in;
      d_ff     <= d_in;
      rem_ff   <= rem_in;
      ctl_ff   <= ctl_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      steer_ff <= steer_in;
   end

   // -------------------------------------------------------- assertions
   a_accept_starts_mul: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_MUL)
      else $error("accepted item did not start the multiplier");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside the output cycle");

   a_no_div_on_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> !dz_ff)
      else $error("divider running with a zero run length");

   a_rsp_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (left_ff != SAT_LO[OUT_W-1:0] - 1'b1)
                    && (right_ff != SAT_LO[OUT_W-1:0] - 1'b1)
                    && (steer_ff != SAT_LO[OUT_W-1:0] - 1'b1))
      else $error("result outside the saturation range");

endmodule
